// ===== src/dice_score_label_maps_macros.svh =====
// Assertion macros for the Dice score block.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef DICE_SCORE_LABEL_MAPS_MACROS_SVH
`define DICE_SCORE_LABEL_MAPS_MACROS_SVH

// cause implies condition in the same cycle
`define DSLM_ASSERT_NOW(label, cause, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cause) |-> (cond)) else $error(msg);

// cause implies condition in the next cycle
`define DSLM_ASSERT_NEXT(label, cause, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cause) |=> (cond)) else $error(msg);

`endif

// ===== src/dslm_pkg.sv =====
// Shared constants, item types and divider state type for the Dice score block.
// No dependencies.
package dslm_pkg;

    localparam int COUNT_WIDTH   = 24;
    localparam int FRACTION_BITS = 16;
    localparam int LABEL_W       = 8;
    localparam int SCORE_W       = FRACTION_BITS + 1;
    localparam int SUM_W         = COUNT_WIDTH + 1;
    localparam int NUM_W         = COUNT_WIDTH + FRACTION_BITS + 2;
    localparam int STEP_W        = $clog2(SCORE_W);
    localparam int SCORE_FIELD_W = 17;
    localparam int TOTAL_FIELD_W = 24;

    localparam logic [LABEL_W-1:0]     LABEL_NONE  = LABEL_W'(0);
    localparam logic [LABEL_W-1:0]     LABEL_ONE   = LABEL_W'(1);
    localparam logic [LABEL_W-1:0]     LABEL_TWO   = LABEL_W'(2);
    localparam logic [LABEL_W-1:0]     LABEL_THREE = LABEL_W'(3);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam logic [SCORE_W-1:0]     SCORE_ONE   = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic [7:0] label_first;
        logic [7:0] label_second;
        logic       last_voxel;
    } in_item_t;

    typedef struct packed {
        logic [16:0] dice_score;
        logic        both_empty;
        logic [23:0] agree_total;
        logic [23:0] nonzero_first_total;
        logic [23:0] nonzero_second_total;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] agree;
        logic [COUNT_WIDTH-1:0] nz_first;
        logic [COUNT_WIDTH-1:0] nz_second;
    } counts_t;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_SUM,
        DIV_LOAD,
        DIV_STEP,
        DIV_DONE
    } div_state_t;

    function automatic logic [TOTAL_FIELD_W-1:0] to_total_field(
        input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[TOTAL_FIELD_W-1:0];
    endfunction

    function automatic logic [SCORE_FIELD_W-1:0] to_score_field(
        input logic [SCORE_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[SCORE_FIELD_W-1:0];
    endfunction

endpackage

// ===== src/dslm_count.sv =====
// Saturating voxel counters: nonzero labels per map and agreeing pairs.
// Depends on dslm_pkg.
module dslm_count import dslm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     take_i,
    input  in_item_t item_i,
    output counts_t  upd_o
);

    counts_t cnt_reg;
    counts_t cnt_next;
    logic    first_nz;
    logic    second_nz;
    logic    agrees;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(
        input logic [COUNT_WIDTH-1:0] v, input logic en);
        return (en && v != COUNT_MAX) ? v + COUNT_WIDTH'(1) : v;
    endfunction

    // labels 1 and 2 are swapped between the maps
    always_comb begin
        first_nz  = item_i.label_first != LABEL_NONE;
        second_nz = item_i.label_second != LABEL_NONE;
        agrees    = first_nz &&
                    ((item_i.label_first == LABEL_ONE && item_i.label_second == LABEL_TWO) ||
                     (item_i.label_first == LABEL_TWO && item_i.label_second == LABEL_ONE) ||
                     (item_i.label_first == LABEL_THREE &&
                      item_i.label_second == LABEL_THREE));
    end

    always_comb begin
        upd_o.agree     = sat_inc(cnt_reg.agree, agrees);
        upd_o.nz_first  = sat_inc(cnt_reg.nz_first, first_nz);
        upd_o.nz_second = sat_inc(cnt_reg.nz_second, second_nz);
        cnt_next        = cnt_reg;
        if (take_i) begin
            cnt_next = item_i.last_voxel ? '0 : upd_o;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/dslm_div.sv =====
// Bit-serial restoring divider producing the rounded Dice score, one quotient bit a cycle.
// Depends on dslm_pkg.
module dslm_div import dslm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start_i,
    input  counts_t   counts_i,
    input  logic      out_free_i,
    output logic      res_valid_o,
    output out_item_t res_o
);

    div_state_t              state_reg;
    div_state_t              state_next;
    counts_t                 counts_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        rem_next;
    logic [SCORE_W-1:0]      numlo_reg;
    logic [SCORE_W-1:0]      quot_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [NUM_W-1:0]        num;
    logic [SUM_W+1:0]        diff;
    logic                    fits;
    logic                    empty;
    logic [SCORE_W-1:0]      score;

    always_comb begin
        // 2*agree*2^F + sum/2
        num  = NUM_W'({counts_reg.agree, SCORE_W'(0)}) + NUM_W'(sum_reg >> 1);
        diff = {1'b0, rem_reg, numlo_reg[SCORE_W-1]} - {2'b00, sum_reg};
        fits = !diff[SUM_W+1];
        rem_next = fits ? diff[SUM_W-1:0] : {rem_reg[SUM_W-2:0], numlo_reg[SCORE_W-1]};
        empty = sum_reg == '0;
        if (empty) begin
            score = '0;
        end else if (quot_reg > SCORE_ONE) begin
            score = SCORE_ONE;
        end else begin
            score = quot_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        res_valid_o = 1'b0;
        unique case (state_reg)
            DIV_IDLE: if (start_i) begin
                state_next = DIV_SUM;
            end
            DIV_SUM:  state_next = DIV_LOAD;
            DIV_LOAD: state_next = DIV_STEP;
            DIV_STEP: if (step_reg == '0) begin
                state_next = DIV_DONE;
            end
            DIV_DONE: begin
                res_valid_o = 1'b1;
                if (out_free_i) begin
                    state_next = DIV_IDLE;
                end
            end
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            DIV_IDLE: if (start_i) begin
                counts_reg <= counts_i;
            end
            DIV_SUM: begin
                sum_reg <= SUM_W'(counts_reg.nz_first) + SUM_W'(counts_reg.nz_second);
            end
            DIV_LOAD: begin
                // top bits are below the divisor, as the score never exceeds one
                rem_reg   <= num[NUM_W-1:SCORE_W];
                numlo_reg <= num[SCORE_W-1:0];
                quot_reg  <= '0;
                step_reg  <= STEP_W'(SCORE_W - 1);
            end
            DIV_STEP: begin
                rem_reg   <= rem_next;
                numlo_reg <= {numlo_reg[SCORE_W-2:0], 1'b0};
                quot_reg  <= {quot_reg[SCORE_W-2:0], fits};
                step_reg  <= step_reg - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_o.dice_score           = to_score_field(score);
        res_o.both_empty           = empty;
        res_o.agree_total          = to_total_field(counts_reg.agree);
        res_o.nonzero_first_total  = to_total_field(counts_reg.nz_first);
        res_o.nonzero_second_total = to_total_field(counts_reg.nz_second);
    end

endmodule

// ===== src/dice_score_label_maps.sv =====
// Dice score of two label maps: counters, serial divider and output register.
// Depends on dslm_pkg, dslm_count, dslm_div and dice_score_label_maps_macros.svh.
// Items without the last mark: one item a cycle, no result.
// Last item: the divider passes through SUM, LOAD, STEP (one quotient bit a cycle) and DONE, then the
// result is registered; no item is taken until the result reaches the output register.
// Synchronous active-low reset clears counters, divider state and output valid.
`include "dice_score_label_maps_macros.svh"
module dice_score_label_maps import dslm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      take;
    logic      busy_reg;
    logic      busy_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_item_reg;
    logic      out_free;
    logic      res_valid;
    out_item_t res;
    counts_t   upd;

    assign s_ready  = !busy_reg;
    assign take     = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    dslm_count u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take_i  (take),
        .item_i  (s_item),
        .upd_o   (upd)
    );

    dslm_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (take && s_item.last_voxel),
        .counts_i    (upd),
        .out_free_i  (out_free),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    always_comb begin
        busy_next = busy_reg;
        if (take && s_item.last_voxel) begin
            busy_next = 1'b1;
        end else if (res_valid && out_free) begin
            busy_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_item_reg <= res;
        end
    end

    `DSLM_ASSERT_NOW(a_empty_zero, m_valid && m_item.both_empty, m_item.dice_score == '0, "empty maps must give zero score")
    `DSLM_ASSERT_NOW(a_score_max, m_valid, m_item.dice_score <= to_score_field(SCORE_ONE), "score above one")
    `DSLM_ASSERT_NEXT(a_hold_after_last, take && s_item.last_voxel, !s_ready, "item taken while dividing")
    `DSLM_ASSERT_NOW(a_result_needs_busy, res_valid, busy_reg, "divider result without pending last item")

endmodule
